// ----- src/rlekd_pkg.sv -----
// shared constants, types and helpers of the run-length key/delta frame decoder
package rlekd_pkg;

  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 200;

  localparam int          POS_W     = 17;
  localparam logic [16:0] POS_MAX   = 17'h1FFFF;
  localparam logic [16:0] FRAME_CAP = 17'(FRAME_WIDTH * FRAME_HEIGHT);

  // start line (16 bits) times line width
  localparam int PROD_W = 16 + $clog2(FRAME_WIDTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_kind;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] write_addr;
    logic [6:0]  write_len;
    logic [7:0]  write_value;
    logic        is_fill;
  } result_t;

  function automatic logic [16:0] pos_sat(input logic [17:0] s);
    pos_sat = (s > {1'b0, POS_MAX}) ? POS_MAX : s[16:0];
  endfunction

endpackage

// ----- src/rlekd_in_if.sv -----
// byte channel carrying the compressed frame payload
interface rlekd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_kind;
  logic       last_byte;

  modport source(output valid, data_byte, frame_kind, last_byte, input ready);
  modport sink(input valid, data_byte, frame_kind, last_byte, output ready);
endinterface

// ----- src/rlekd_out_if.sv -----
// write command channel toward the frame memory
interface rlekd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] write_addr;
  logic [6:0]  write_len;
  logic [7:0]  write_value;
  logic        is_fill;

  modport source(output valid, write_addr, write_len, write_value, is_fill, input ready);
  modport sink(input valid, write_addr, write_len, write_value, is_fill, output ready);
endinterface

// ----- src/rlekd_in_stage.sv -----
// input register for one payload beat
module rlekd_in_stage (
  input  logic                clk,
  input  logic                rst,
  rlekd_in_if.sink            payload,
  input  logic                pull,
  output logic                valid,
  output rlekd_pkg::item_t    item
);

  assign payload.ready = !valid || pull;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (payload.ready) begin
      valid <= payload.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (payload.valid && payload.ready) begin
      item.data_byte  <= payload.data_byte;
      item.frame_kind <= payload.frame_kind;
      item.last_byte  <= payload.last_byte;
    end
  end

endmodule

// ----- src/rlekd_parser.sv -----
// parse state and per-byte decode of key and delta frame payloads
module rlekd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  rlekd_pkg::item_t    item,
  output logic                res_valid,
  output rlekd_pkg::result_t  res
);

  localparam logic [3:0] PH_FIRST   = 4'd0;
  localparam logic [3:0] PH_HDR0    = 4'd1;
  localparam logic [3:0] PH_HDR1    = 4'd2;
  localparam logic [3:0] PH_HDR2    = 4'd3;
  localparam logic [3:0] PH_HDR3    = 4'd4;
  localparam logic [3:0] PH_RUNS    = 4'd5;
  localparam logic [3:0] PH_SKIP    = 4'd6;
  localparam logic [3:0] PH_TAG     = 4'd7;
  localparam logic [3:0] PH_COLOR   = 4'd8;
  localparam logic [3:0] PH_LITERAL = 4'd9;
  localparam logic [3:0] PH_DONE    = 4'd10;

  localparam int PW = rlekd_pkg::PROD_W;

  logic [3:0]  parse_phase, parse_phase_next;
  logic        mode_is_delta, mode_is_delta_next;
  logic [7:0]  header_low_byte, header_low_byte_next;
  logic [16:0] line_base, line_base_next;      // start line times width, saturated
  logic        line_beyond, line_beyond_next;  // start line past frame end
  logic [15:0] lines_left, lines_left_next;
  logic [6:0]  runs_left, runs_left_next;
  logic [6:0]  literal_left, literal_left_next;
  logic [16:0] line_start_addr, line_start_addr_next;
  logic [16:0] pixel_pos, pixel_pos_next;

  // effective values after the first-byte setup
  logic [3:0]  ph;
  logic        delta;
  logic [15:0] ll;
  logic [16:0] lsa;
  logic [16:0] pos;

  logic [7:0]    b;
  logic [7:0]    neg_b;
  logic [15:0]   hdr_word;
  logic [PW-1:0] prod;
  logic [16:0]   nl_lsa;
  logic [15:0]   nl_ll;
  logic [6:0]    fr_runs;
  logic [16:0]   rem;
  logic [6:0]    len;
  logic [6:0]    lit_count;
  logic          do_lit;
  logic          do_finish;
  logic          do_nl;

  always_comb begin
    b        = item.data_byte;
    neg_b    = 8'(8'd0 - item.data_byte);
    hdr_word = {item.data_byte, header_low_byte};
    prod     = PW'(hdr_word) * PW'(rlekd_pkg::FRAME_WIDTH);

    ph    = parse_phase;
    delta = mode_is_delta;
    ll    = lines_left;
    lsa   = line_start_addr;
    pos   = pixel_pos;
    if (parse_phase == PH_FIRST) begin
      delta = item.frame_kind;
      if (item.frame_kind) begin
        ph = PH_HDR0;
      end else begin
        ll  = 16'(rlekd_pkg::FRAME_HEIGHT);
        lsa = '0;
        pos = '0;
        ph  = PH_RUNS;
      end
    end

    nl_lsa  = rlekd_pkg::pos_sat(18'(lsa) + 18'(rlekd_pkg::FRAME_WIDTH));
    nl_ll   = ll - 16'd1;
    fr_runs = runs_left - 7'd1;
    rem     = rlekd_pkg::FRAME_CAP - pos;
    len     = ({10'd0, literal_left} > rem) ? rem[6:0] : literal_left;

    parse_phase_next     = ph;
    mode_is_delta_next   = delta;
    header_low_byte_next = header_low_byte;
    line_base_next       = line_base;
    line_beyond_next     = line_beyond;
    lines_left_next      = ll;
    runs_left_next       = runs_left;
    literal_left_next    = literal_left;
    line_start_addr_next = lsa;
    pixel_pos_next       = pos;

    res_valid       = 1'b0;
    res.write_addr  = pos[15:0];
    res.write_len   = 7'd1;
    res.write_value = b;
    res.is_fill     = 1'b0;

    lit_count = '0;
    do_lit    = 1'b0;
    do_finish = 1'b0;
    do_nl     = 1'b0;

    case (ph)
      PH_HDR0: begin
        header_low_byte_next = b;
        parse_phase_next     = PH_HDR1;
      end
      PH_HDR1: begin
        line_beyond_next = prod > PW'(rlekd_pkg::FRAME_CAP);
        line_base_next   = (prod > PW'(rlekd_pkg::POS_MAX)) ? rlekd_pkg::POS_MAX : prod[16:0];
        parse_phase_next = PH_HDR2;
      end
      PH_HDR2: begin
        header_low_byte_next = b;
        parse_phase_next     = PH_HDR3;
      end
      PH_HDR3: begin
        if (hdr_word == 16'd0 || hdr_word[15] || line_beyond) begin
          parse_phase_next = PH_DONE;
        end else begin
          lines_left_next      = hdr_word;
          line_start_addr_next = line_base;
          pixel_pos_next       = line_base;
          parse_phase_next     = PH_RUNS;
        end
      end
      PH_RUNS: begin
        if (b == 8'd0 || b[7]) begin
          do_nl = 1'b1;
        end else begin
          runs_left_next   = b[6:0];
          parse_phase_next = delta ? PH_SKIP : PH_TAG;
        end
      end
      PH_SKIP: begin
        pixel_pos_next   = rlekd_pkg::pos_sat({1'b0, pos} + 18'(b));
        parse_phase_next = PH_TAG;
      end
      PH_TAG: begin
        if (delta) begin
          if (b != 8'd0 && !b[7]) begin
            do_lit    = 1'b1;
            lit_count = b[6:0];
          end else begin
            // a tag of -128 asks for 128 pixels, clipped to 127
            literal_left_next = neg_b[7] ? 7'd127 : neg_b[6:0];
            parse_phase_next  = PH_COLOR;
          end
        end else begin
          if (b[7]) begin
            do_lit    = 1'b1;
            lit_count = neg_b[6:0];
          end else begin
            literal_left_next = b[6:0];
            parse_phase_next  = PH_COLOR;
          end
        end
      end
      PH_COLOR: begin
        if (literal_left != 7'd0 && pos < rlekd_pkg::FRAME_CAP) begin
          res_valid      = 1'b1;
          res.write_len  = len;
          res.is_fill    = 1'b1;
          pixel_pos_next = rlekd_pkg::pos_sat({1'b0, pos} + 18'(len));
        end
        do_finish = 1'b1;
      end
      PH_LITERAL: begin
        if (pos < rlekd_pkg::FRAME_CAP) begin
          res_valid      = 1'b1;
          pixel_pos_next = pos + 17'd1;
        end
        if (literal_left == 7'd0 || pixel_pos_next >= rlekd_pkg::FRAME_CAP) begin
          do_finish = 1'b1;
        end else begin
          literal_left_next = literal_left - 7'd1;
        end
      end
      default: begin
      end
    endcase

    if (do_lit) begin
      if (pos >= rlekd_pkg::FRAME_CAP) begin
        do_finish = 1'b1;
      end else begin
        literal_left_next = lit_count - 7'd1;
        parse_phase_next  = PH_LITERAL;
      end
    end

    if (do_finish) begin
      runs_left_next = fr_runs;
      if (fr_runs == 7'd0) begin
        do_nl = 1'b1;
      end else begin
        parse_phase_next = delta ? PH_SKIP : PH_TAG;
      end
    end

    if (do_nl) begin
      line_start_addr_next = nl_lsa;
      pixel_pos_next       = nl_lsa;
      lines_left_next      = nl_ll;
      parse_phase_next     = (nl_ll == 16'd0) ? PH_DONE : PH_RUNS;
    end

    if (item.last_byte) begin
      parse_phase_next = PH_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_FIRST;
      mode_is_delta   <= 1'b0;
      header_low_byte <= '0;
      line_base       <= '0;
      line_beyond     <= 1'b0;
      lines_left      <= '0;
      runs_left       <= '0;
      literal_left    <= '0;
      line_start_addr <= '0;
      pixel_pos       <= '0;
    end else if (fire) begin
      parse_phase     <= parse_phase_next;
      mode_is_delta   <= mode_is_delta_next;
      header_low_byte <= header_low_byte_next;
      line_base       <= line_base_next;
      line_beyond     <= line_beyond_next;
      lines_left      <= lines_left_next;
      runs_left       <= runs_left_next;
      literal_left    <= literal_left_next;
      line_start_addr <= line_start_addr_next;
      pixel_pos       <= pixel_pos_next;
    end
  end

  property p_after_last;
    @(posedge clk) disable iff (rst)
      fire && item.last_byte |=> parse_phase == PH_FIRST;
  endproperty
  a_after_last: assert property (p_after_last)
    else $error("parser not back at payload start after final byte");

  property p_literal_single;
    @(posedge clk) disable iff (rst)
      res_valid && !res.is_fill |-> res.write_len == 7'd1;
  endproperty
  a_literal_single: assert property (p_literal_single)
    else $error("literal write longer than one pixel");

  property p_no_write_idle;
    @(posedge clk) disable iff (rst)
      (parse_phase == PH_DONE || parse_phase == PH_RUNS) |-> !res_valid;
  endproperty
  a_no_write_idle: assert property (p_no_write_idle)
    else $error("write produced outside a run");

endmodule

// ----- src/rlekd_out_stage.sv -----
// result register holding one write command until it is taken
module rlekd_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  rlekd_pkg::result_t  res,
  output logic                space,
  rlekd_out_if.source         writes
);

  rlekd_pkg::result_t held;

  assign space = !writes.valid || writes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      writes.valid <= 1'b0;
    end else if (space) begin
      writes.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      held <= res;
    end
  end

  assign writes.write_addr  = held.write_addr;
  assign writes.write_len   = held.write_len;
  assign writes.write_value = held.write_value;
  assign writes.is_fill     = held.is_fill;

endmodule

// ----- src/rle_key_delta_frame_decoder.sv -----
// top level of the run-length key/delta frame decoder
//
// payload: one compressed byte per beat (data_byte, frame_kind, last_byte);
//   frame_kind is looked at only on the first beat of a payload, and the beat
//   with last_byte set closes the payload so the next beat starts a new one
// writes: at most one write command per payload beat (write_addr, write_len,
//   write_value, is_fill) for an external 320 x 200 frame buffer, never read
// throughput: one payload beat per cycle, sustained, as long as writes is taken
// decode path: a beat waits in the input register and is decoded in a
//   single pass of the parser into the result register, which drives
//   writes.valid; a held-off writes side keeps the beat in the input register
// stall: when writes is held off, the result register keeps its command and
//   the parser freezes; payload.ready drops once the input register is also full,
//   so nothing is lost or repeated
// reset: rst (synchronous) empties both registers and sets the parser to wait
//   for the first beat of a payload; no clearing pass is needed
// the longest decode path is the start-line times width multiply on the second
//   delta header beat and its compare against the frame end; both results are
//   registered for the line count beats
module rle_key_delta_frame_decoder (
  input  logic         clk,
  input  logic         rst,
  rlekd_in_if.sink     payload,
  rlekd_out_if.source  writes
);

  logic               item_valid;
  rlekd_pkg::item_t   item;
  logic               space;
  logic               fire;
  logic               res_valid;
  rlekd_pkg::result_t res;

  // a held beat is decoded whenever the result register can take its output
  assign fire = item_valid && space;

  rlekd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .payload (payload),
    .pull    (space),
    .valid   (item_valid),
    .item    (item)
  );

  rlekd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  rlekd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (fire && res_valid),
    .res    (res),
    .space  (space),
    .writes (writes)
  );

  // writes stay inside the frame
  property p_in_frame;
    @(posedge clk) disable iff (rst)
      writes.valid |-> 17'(writes.write_addr) + 17'(writes.write_len)
                       <= rlekd_pkg::FRAME_CAP;
  endproperty
  a_in_frame: assert property (p_in_frame)
    else $error("write runs past frame end");

  // no empty writes
  property p_len_nonzero;
    @(posedge clk) disable iff (rst)
      writes.valid |-> writes.write_len != 7'd0;
  endproperty
  a_len_nonzero: assert property (p_len_nonzero)
    else $error("write of zero pixels");

  // a decoded beat never overwrites a command still waiting
  property p_no_overrun;
    @(posedge clk) disable iff (rst)
      writes.valid && !writes.ready |-> !fire;
  endproperty
  a_no_overrun: assert property (p_no_overrun)
    else $error("decode while result register blocked");

endmodule

// ----- verif/rlekd_write_check.sv -----
// write checker: decodes each accepted payload beat on its own and compares the frame writes
module rlekd_write_check (
  input  logic  clk,
  input  logic  rst,
  rlekd_in_if   payload,
  rlekd_out_if  writes,
  output int    fail_cnt,
  output int    writes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_END = rlekd_pkg::FRAME_WIDTH * rlekd_pkg::FRAME_HEIGHT;

  typedef enum logic [3:0] {
    PARSE_FIRST, PARSE_HDR0, PARSE_HDR1, PARSE_HDR2, PARSE_HDR3, PARSE_RUNS,
    PARSE_SKIP, PARSE_TAG, PARSE_COLOR, PARSE_COPY, PARSE_DONE
  } parse_t;

  parse_t      phase;
  logic        delta;
  logic [7:0]  hdr_lo;
  logic [15:0] first_line;
  logic [15:0] lines_left;
  logic [6:0]  runs_left;
  logic [6:0]  count_left;  // literal bytes left minus one, or clipped fill count
  logic [16:0] line_addr;
  logic [16:0] pos;

  rlekd_pkg::result_t expected_writes[$];
  int                 errors = 0;
  int                 depth = 0;

  assign fail_cnt       = errors;
  assign writes_pending = depth;

  task automatic report(input string msg);
    errors++;
    $display("%0t ns write mismatch: %s", $realtime, msg);
  endtask

  function automatic logic [16:0] pos_add(input logic [16:0] a, input int b);
    int s;
    s = int'(a) + b;
    return (s > int'(rlekd_pkg::POS_MAX)) ? rlekd_pkg::POS_MAX : 17'(s);
  endfunction

  task automatic next_row();
    line_addr  = pos_add(line_addr, rlekd_pkg::FRAME_WIDTH);
    pos        = line_addr;
    lines_left = lines_left - 16'd1;
    phase      = (lines_left == 16'd0) ? PARSE_DONE : PARSE_RUNS;
  endtask

  task automatic end_run();
    runs_left = runs_left - 7'd1;
    if (runs_left == 7'd0) begin
      next_row();
    end else begin
      phase = delta ? PARSE_SKIP : PARSE_TAG;
    end
  endtask

  // a copy that starts at the frame end is dropped whole
  task automatic begin_copy(input int n);
    if (int'(pos) >= FRAME_END) begin
      end_run();
    end else begin
      count_left = 7'(n - 1);
      phase      = PARSE_COPY;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic kind, input logic last,
                             output bit hit, output rlekd_pkg::result_t w);
    int          sv;
    int          len;
    int          span;
    logic [15:0] h;
    hit = 1'b0;
    w   = '0;
    sv  = int'($signed(b));
    if (phase == PARSE_FIRST) begin
      delta = kind;
      if (kind) begin
        phase = PARSE_HDR0;
      end else begin
        lines_left = 16'(rlekd_pkg::FRAME_HEIGHT);
        line_addr  = '0;
        pos        = '0;
        phase      = (lines_left == 16'd0) ? PARSE_DONE : PARSE_RUNS;
      end
    end
    case (phase)
      PARSE_HDR0: begin
        hdr_lo = b;
        phase  = PARSE_HDR1;
      end
      PARSE_HDR1: begin
        first_line = {b, hdr_lo};
        phase      = PARSE_HDR2;
      end
      PARSE_HDR2: begin
        hdr_lo = b;
        phase  = PARSE_HDR3;
      end
      PARSE_HDR3: begin
        h    = {b, hdr_lo};
        span = int'(first_line) * rlekd_pkg::FRAME_WIDTH;
        if (h == 16'd0 || h[15] || span > FRAME_END) begin
          phase = PARSE_DONE;
        end else begin
          lines_left = h;
          line_addr  = (span > int'(rlekd_pkg::POS_MAX)) ? rlekd_pkg::POS_MAX : 17'(span);
          pos        = line_addr;
          phase      = PARSE_RUNS;
        end
      end
      PARSE_RUNS: begin
        if (sv <= 0) begin
          next_row();
        end else begin
          runs_left = 7'(sv);
          phase     = delta ? PARSE_SKIP : PARSE_TAG;
        end
      end
      PARSE_SKIP: begin
        pos   = pos_add(pos, int'(b));
        phase = PARSE_TAG;
      end
      PARSE_TAG: begin
        if (delta) begin
          if (sv > 0) begin
            begin_copy(sv);
          end else begin
            count_left = (-sv > 127) ? 7'd127 : 7'(-sv);
            phase      = PARSE_COLOR;
          end
        end else begin
          if (sv < 0) begin
            begin_copy(-sv);
          end else begin
            count_left = 7'(sv);
            phase      = PARSE_COLOR;
          end
        end
      end
      PARSE_COLOR: begin
        if (count_left != 7'd0 && int'(pos) < FRAME_END) begin
          len = int'(count_left);
          if (len > FRAME_END - int'(pos))
            len = FRAME_END - int'(pos);
          w.write_addr  = pos[15:0];
          w.write_len   = 7'(len);
          w.write_value = b;
          w.is_fill     = 1'b1;
          hit           = 1'b1;
          pos           = pos_add(pos, len);
        end
        end_run();
      end
      PARSE_COPY: begin
        if (int'(pos) < FRAME_END) begin
          w.write_addr  = pos[15:0];
          w.write_len   = 7'd1;
          w.write_value = b;
          w.is_fill     = 1'b0;
          hit           = 1'b1;
          pos           = pos_add(pos, 1);
        end
        if (count_left == 7'd0 || int'(pos) >= FRAME_END) begin
          end_run();
        end else begin
          count_left = count_left - 7'd1;
        end
      end
      default: begin
      end
    endcase
    if (last)
      phase = PARSE_FIRST;
  endtask

  always @(posedge clk) begin
    rlekd_pkg::result_t got;
    rlekd_pkg::result_t want;
    rlekd_pkg::result_t w;
    bit                 hit;
    if (rst) begin
      phase      = PARSE_FIRST;
      delta      = 1'b0;
      hdr_lo     = '0;
      first_line = '0;
      lines_left = '0;
      runs_left  = '0;
      count_left = '0;
      line_addr  = '0;
      pos        = '0;
      expected_writes.delete();
    end else begin
      // writes first: a beat accepted now cannot have its write out yet
      if (writes.valid && writes.ready) begin
        got.write_addr  = writes.write_addr;
        got.write_len   = writes.write_len;
        got.write_value = writes.write_value;
        got.is_fill     = writes.is_fill;
        if (expected_writes.size() == 0) begin
          report($sformatf("unexpected write addr %0d len %0d value %0d fill %0b",
                           got.write_addr, got.write_len, got.write_value, got.is_fill));
        end else begin
          want = expected_writes.pop_front();
          if (got.write_addr !== want.write_addr)
            report($sformatf("write_addr %0d, want %0d", got.write_addr, want.write_addr));
          if (got.write_len !== want.write_len)
            report($sformatf("write_len %0d at %0d, want %0d",
                             got.write_len, want.write_addr, want.write_len));
          if (got.write_value !== want.write_value)
            report($sformatf("write_value %0d at %0d, want %0d",
                             got.write_value, want.write_addr, want.write_value));
          if (got.is_fill !== want.is_fill)
            report($sformatf("is_fill %0b at %0d, want %0b",
                             got.is_fill, want.write_addr, want.is_fill));
        end
      end
      if (payload.valid && payload.ready) begin
        decode_byte(payload.data_byte, payload.frame_kind, payload.last_byte, hit, w);
        if (hit)
          expected_writes.push_back(w);
      end
    end
    depth <= expected_writes.size();
  end

endmodule

// ----- verif/rle_key_delta_frame_decoder_tb.sv -----
// testbench top: payload stimulus, write-side flow control and the final verdict
module rle_key_delta_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // stimulus stops once this many payload beats went in
  localparam int TARGET_BEATS = 650;
  // from here on neither side idles
  localparam int QUIET_AFTER  = 600;
  // long write-side hold that fills the block and backs up the payload side
  localparam int HOLD_CYCLES  = 64;
  // extra wait after the writes drain, to catch stray writes at the end
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst;
  int   fail_cnt;
  int   writes_pending;
  int   beats_sent = 0;
  bit   quiet = 1'b0;     // no idling for the current payload
  bit   hold_req = 1'b0;  // asks the write side for one long hold

  // beats of the payload being built, sent as a whole
  rlekd_pkg::item_t payload_q[$];

  rlekd_in_if  payload();
  rlekd_out_if writes();

  rle_key_delta_frame_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .payload (payload),
    .writes  (writes)
  );

  rlekd_write_check u_write_check (
    .clk            (clk),
    .rst            (rst),
    .payload        (payload),
    .writes         (writes),
    .fail_cnt       (fail_cnt),
    .writes_pending (writes_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #400_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // one payload byte; frame_kind only matters on the first beat, so it is random here
  task automatic put(input logic [7:0] b);
    rlekd_pkg::item_t it;
    it.data_byte  = b;
    it.frame_kind = 1'($urandom);
    it.last_byte  = 1'b0;
    payload_q.push_back(it);
  endtask

  // set the kind on the first beat, optionally end the payload early, mark the
  // last beat and push every beat through the handshake
  task automatic send_payload(input logic kind, input bit cut);
    rlekd_pkg::item_t it;
    int               keep;
    it            = payload_q[0];
    it.frame_kind = kind;
    payload_q[0]  = it;
    if (cut) begin
      keep = $urandom_range(1, payload_q.size());
      while (payload_q.size() > keep)
        void'(payload_q.pop_back());
    end
    it           = payload_q[$];
    it.last_byte = 1'b1;
    payload_q[$] = it;
    quiet = $urandom_range(0, 4) == 0;
    while (payload_q.size() > 0) begin
      it = payload_q.pop_front();
      if (!quiet && beats_sent < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
        payload.valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      payload.valid      <= 1'b1;
      payload.data_byte  <= it.data_byte;
      payload.frame_kind <= it.frame_kind;
      payload.last_byte  <= it.last_byte;
      do @(posedge clk); while (payload.ready !== 1'b1);
      beats_sent++;
    end
  endtask

  // one run after its skip byte: a literal copy or a fill with its colour;
  // the tag sign convention flips between key and delta frames
  task automatic gen_run(input bit delta);
    int n;
    if ($urandom_range(0, 4) < 2) begin
      // rare full-length copy: 127 in a delta frame, 128 (tag -128) in a key frame
      n = ($urandom_range(0, 19) == 0) ? (delta ? 127 : 128) : $urandom_range(1, 6);
      put(delta ? 8'(n) : 8'(-n));
      repeat (n) put(8'($urandom));
    end else begin
      case ($urandom_range(0, 5))
        0:       n = 0;
        1:       n = delta ? 128 : 127;
        default: n = $urandom_range(1, 40);
      endcase
      put(delta ? 8'(-n) : 8'(n));
      put(8'($urandom));
    end
  endtask

  // one line: sometimes empty (zero or negative run count), else a few runs
  task automatic gen_line(input bit delta, input int max_runs);
    int runs;
    if ($urandom_range(0, 5) == 0) begin
      put($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(128, 255)));
    end else begin
      runs = $urandom_range(1, max_runs);
      put(8'(runs));
      repeat (runs) begin
        if (delta) begin
          case ($urandom_range(0, 4))
            0:       put(8'hFF);
            1:       put(8'($urandom));
            default: put(8'($urandom_range(0, 8)));
          endcase
        end
        gen_run(delta);
      end
    end
  endtask

  // write side: random short holds, one long hold on request, none at the end
  initial begin
    int n;
    writes.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        writes.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++)
          @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && beats_sent < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
        writes.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        writes.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [7:0] seq[$];
    int         first_line;
    int         line_cnt;
    int         n;
    rst                <= 1'b1;
    payload.valid      <= 1'b0;
    payload.data_byte  <= '0;
    payload.frame_kind <= 1'b0;
    payload.last_byte  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // key frame cut short: empty line by zero count, empty line by negative
    // count, then zero-length fill, widest key fill and a two-byte copy
    seq = '{8'h00, 8'hFF, 8'h03, 8'h00, 8'h33, 8'h7F, 8'hFF, 8'hFE, 8'h00, 8'h80};
    foreach (seq[i]) put(seq[i]);
    send_payload(1'b0, 1'b0);

    // delta on the last line: tag -128 clipped to 127, a fill clipped at the
    // frame end, a copy starting at the frame end, then a byte after all lines
    seq = '{8'hC7, 8'h00, 8'h01, 8'h00, 8'h03, 8'h00, 8'h80, 8'h5A,
            8'h7F, 8'h80, 8'hA5, 8'h00, 8'h03, 8'h7F};
    foreach (seq[i]) put(seq[i]);
    send_payload(1'b1, 1'b0);

    // delta header with zero lines: the rest is ignored
    seq = '{8'h10, 8'h00, 8'h00, 8'h00};
    foreach (seq[i]) put(seq[i]);
    send_payload(1'b1, 1'b0);

    // delta header whose start line is past the frame
    seq = '{8'hC9, 8'h00, 8'h01, 8'h00};
    foreach (seq[i]) put(seq[i]);
    send_payload(1'b1, 1'b0);

    for (int p = 0; beats_sent < TARGET_BEATS; p++) begin
      if (p == 0) begin
        // long copy while the write side holds: block fills, payload stalls
        hold_req = 1'b1;
        seq = '{8'h0A, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h28};
        foreach (seq[i]) put(seq[i]);
        repeat (40) put(8'($urandom));
        send_payload(1'b1, 1'b0);
      end else if (p == 1) begin
        // whole key frame, mostly empty lines; the last line runs fills to
        // near the frame end and a copy that hits it, so the copy's tail
        // bytes come after all lines are done
        for (n = 0; n < rlekd_pkg::FRAME_HEIGHT - 1; n++) begin
          if ($urandom_range(0, 39) == 0)
            gen_line(1'b0, 3);
          else
            put($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(128, 255)));
        end
        seq = '{8'h04, 8'h7F, 8'($urandom), 8'h7F, 8'($urandom), 8'h3C, 8'($urandom), 8'hF6};
        foreach (seq[i]) put(seq[i]);
        repeat (12) put(8'($urandom));
        send_payload(1'b0, 1'b0);
      end else if (p == 2) begin
        // delta from the frame end with many lines until the line address
        // saturates; later skips push on the saturated position
        seq = '{8'hC8, 8'h00, 8'h2C, 8'h01};
        foreach (seq[i]) put(seq[i]);
        for (n = 0; n < 226; n++) begin
          if (n % 45 == 20) begin
            seq = '{8'h01, 8'hFF, 8'hFD, 8'($urandom)};
            foreach (seq[i]) put(seq[i]);
          end else begin
            put(n % 2 ? 8'h00 : 8'($urandom_range(128, 255)));
          end
        end
        seq = '{8'h02, 8'hFF, 8'h05, 8'hFF, 8'h81, 8'($urandom)};
        foreach (seq[i]) put(seq[i]);
        send_payload(1'b1, 1'b0);
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
            // well-formed delta frame, start line biased toward the frame end
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: first_line = $urandom_range(0, 199);
              5, 6:          first_line = $urandom_range(195, 200);
              7:             first_line = 0;
              8:             first_line = $urandom_range(201, 65535);
              default:       first_line = 199;
            endcase
            case ($urandom_range(0, 11))
              0:       line_cnt = 0;
              1:       line_cnt = $urandom_range(32768, 65535);
              2:       line_cnt = $urandom_range(100, 32767);
              default: line_cnt = $urandom_range(1, 5);
            endcase
            put(8'(first_line));
            put(8'(first_line >> 8));
            put(8'(line_cnt));
            put(8'(line_cnt >> 8));
            if (line_cnt >= 1 && line_cnt <= 32767) begin
              for (n = 0; n < line_cnt && n < 6; n++)
                gen_line(1'b1, 3);
            end
            if ($urandom_range(0, 2) == 0)
              repeat ($urandom_range(1, 2)) put(8'($urandom));
            send_payload(1'b1, $urandom_range(0, 7) == 0);
          end
          11, 12, 13, 14, 15: begin
            // first lines of a key frame, often cut short
            repeat ($urandom_range(1, 6)) gen_line(1'b0, 3);
            send_payload(1'b0, $urandom_range(0, 3) == 0);
          end
          default: begin
            // noise payload of either kind
            repeat ($urandom_range(1, 12)) put(8'($urandom));
            send_payload(1'($urandom), 1'b0);
          end
        endcase
      end
    end
    payload.valid <= 1'b0;

    // let the checker see the last beat, wait out the writes, then catch strays
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && writes_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
